// ===== design/psfl_pkg.sv =====
package psfl_pkg;

	localparam int ENTRIES = 64;
	localparam int HISTORY = 8;
	localparam int ADDR_W = 32;
	localparam int TIME_W = 48;
	localparam int GAP_W = 32;
	localparam int WP_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int SUM_W = TIME_W + ((HISTORY > 1) ? $clog2(HISTORY) : 0);
	localparam int NPAIR = (HISTORY + 1) / 2;
	localparam int PAIR_W = TIME_W + 1;
	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(500);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [WP_W-1:0] wp_t;
	typedef logic [HISTORY-1:0][TIME_W-1:0] hist_t;

	typedef struct packed {
		logic new_en;
		logic hist_en;
		logic flag_en;
		logic flag_val;
		wp_t slot;
	} cell_cmd_t;

endpackage

// ===== design/psfl_in_if.sv =====
interface psfl_in_if;
	logic valid;
	logic ready;
	logic [31:0] src_addr;
	logic [47:0] now_ms;

	modport source (output valid, output src_addr, output now_ms, input ready);
	modport sink (input valid, input src_addr, input now_ms, output ready);
endinterface

// ===== design/psfl_out_if.sv =====
interface psfl_out_if;
	logic valid;
	logic ready;
	logic allow;
	logic already_logged;
	logic new_entry;
	logic table_full;

	modport source (output valid, output allow, output already_logged, output new_entry,
		output table_full, input ready);
	modport sink (input valid, input allow, input already_logged, input new_entry,
		input table_full, output ready);
endinterface

// ===== design/psfl_cfg_if.sv =====
interface psfl_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/psfl_cell.sv =====
module psfl_cell (
	input logic clk,
	input logic arst_n,
	input psfl_pkg::addr_t q_addr,
	input psfl_pkg::time_t q_now,
	input psfl_pkg::cell_cmd_t cmd,
	input logic sel,
	input logic prev_valid,
	output logic valid,
	output logic take,
	output logic match,
	output psfl_pkg::hist_t hist,
	output psfl_pkg::wp_t wp,
	output logic flag
);
	import psfl_pkg::*;

	logic valid_q;
	addr_t addr_q;
	hist_t hist_q;
	wp_t wp_q;
	logic flag_q;

	assign valid = valid_q;
	assign take = prev_valid && !valid_q;
	assign match = valid_q && (addr_q == q_addr);
	assign hist = hist_q;
	assign wp = wp_q;
	assign flag = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.new_en && take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.new_en && take) begin
			addr_q <= q_addr;
			// slot 0 holds now, the rest are zero
			hist_q <= hist_t'(q_now);
			wp_q <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.hist_en && sel) begin
				hist_q[cmd.slot] <= q_now;
				wp_q <= (wp_q == WP_W'(HISTORY - 1)) ? '0 : wp_q + WP_W'(1);
			end
			if (cmd.flag_en && sel) begin
				flag_q <= cmd.flag_val;
			end
		end
	end

endmodule

// ===== design/per_source_flood_limiter.sv =====
// A new or untracked address goes from accept through the match state straight to output;
// a tracked one passes the match, update with pair sums, total, decision and output states.
// Words are handled one at a time through the shared history sum: a new word is taken
// only in the idle state, and the machine stalls while a finished word waits for the receiver.
// A finished word waits in the output register while the next one is taken.
// Reset: all table entries invalid, gap register 500, channels empty.
module per_source_flood_limiter (
	input logic clk,
	input logic arst_n,
	psfl_in_if.sink pkt,
	psfl_out_if.source res,
	psfl_cfg_if.sink cfg
);
	import psfl_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MATCH = 3'd1;
	localparam logic [2:0] ST_UPD = 3'd2;
	localparam logic [2:0] ST_SUM = 3'd3;
	localparam logic [2:0] ST_DEC = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0] state_q;
	logic [GAP_W-1:0] gap_q;
	addr_t addr_q;
	time_t now_q;
	hist_t hsel_q;
	wp_t wpsel_q;
	logic flagsel_q;
	logic [ENTRIES-1:0] sel_q;
	logic [NPAIR-1:0][PAIR_W-1:0] psum_s1;
	logic [SUM_W-1:0] total_s2;
	logic [3:0] res_q;
	logic out_valid_q;
	logic [3:0] out_q;

	cell_cmd_t cmd;
	logic [ENTRIES-1:0] valid_v, take_v, match_v;
	hist_t hist_v [ENTRIES];
	wp_t wp_v [ENTRIES];
	logic [ENTRIES-1:0] flag_v;
	hist_t hsel, hupd;
	wp_t wpsel;
	logic flagsel;
	logic hit, full;
	logic [NPAIR-1:0][PAIR_W-1:0] psum;
	logic [SUM_W-1:0] total, mean, now_x, diff;
	logic deny;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			psfl_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.q_addr(addr_q),
				.q_now(now_q),
				.cmd(cmd),
				.sel(sel_q[g]),
				.prev_valid((g == 0) ? 1'b1 : valid_v[(g == 0) ? 0 : g - 1]),
				.valid(valid_v[g]),
				.take(take_v[g]),
				.match(match_v[g]),
				.hist(hist_v[g]),
				.wp(wp_v[g]),
				.flag(flag_v[g])
			);
		end
	endgenerate

	assign hit = |match_v;
	assign full = valid_v[ENTRIES-1];

	always_comb begin
		hsel = '0;
		wpsel = '0;
		flagsel = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_v[i]) begin
				hsel = hsel | hist_v[i];
				wpsel = wpsel | wp_v[i];
				flagsel = flagsel | flag_v[i];
			end
		end
	end

	always_comb begin
		hupd = hsel_q;
		hupd[wpsel_q] = now_q;
		for (int k = 0; k < NPAIR; k++) begin
			if (2 * k + 1 < HISTORY) begin
				psum[k] = PAIR_W'(hupd[2 * k]) + PAIR_W'(hupd[(2 * k + 1) % HISTORY]);
			end else begin
				psum[k] = PAIR_W'(hupd[2 * k]);
			end
		end
		total = '0;
		for (int k = 0; k < NPAIR; k++) begin
			total = total + SUM_W'(psum_s1[k]);
		end
	end

	assign mean = total_s2 / HISTORY;
	assign now_x = SUM_W'(now_q);
	assign diff = now_x - mean;
	assign deny = (mean <= now_x) && (diff < SUM_W'(gap_q));

	always_comb begin
		cmd = '0;
		cmd.slot = wpsel_q;
		cmd.flag_val = deny;
		cmd.new_en = (state_q == ST_MATCH) && !hit && !full;
		cmd.hist_en = (state_q == ST_UPD);
		cmd.flag_en = (state_q == ST_DEC);
	end

	assign pkt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.allow = out_q[3];
	assign res.already_logged = out_q[2];
	assign res.new_entry = out_q[1];
	assign res.table_full = out_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gap_q <= GAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				gap_q <= cfg.data;
			end
			if (res.ready && (state_q != ST_PUSH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pkt.valid) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= hit ? ST_UPD : ST_PUSH;
				end
				ST_UPD: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			addr_q <= pkt.src_addr;
			now_q <= pkt.now_ms;
		end
		if (state_q == ST_MATCH) begin
			hsel_q <= hsel;
			wpsel_q <= wpsel;
			flagsel_q <= flagsel;
			sel_q <= match_v;
			res_q <= {1'b1, 1'b0, !full, full};
		end
		if (state_q == ST_UPD) begin
			psum_s1 <= psum;
		end
		if (state_q == ST_SUM) begin
			total_s2 <= total;
		end
		if (state_q == ST_DEC) begin
			res_q <= {!deny, deny && flagsel_q, 1'b0, 1'b0};
		end
		if (state_q == ST_PUSH && (!out_valid_q || res.ready)) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_v)) else $error("more than one cell matches");
	a_take_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(take_v)) else $error("more than one free cell takes");
	a_deny_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.allow) |-> (!res.new_entry && !res.table_full))
		else $error("denied word marked new or untracked");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.new_en, cmd.hist_en, cmd.flag_en}))
		else $error("overlapping cell commands");
`endif

endmodule
